// ===== design/assert_macros.svh =====
// assertion macros included by the hash table core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define OAHT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define OAHT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/oaht_pkg.sv =====
// constants, codes and helper functions of the open-addressed hash table
`timescale 1ns / 1ps
package oaht_pkg;
    localparam int MAX_SLOTS  = 256;
    localparam int SLOT_W     = 8;
    localparam int CNT_W      = 9;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int HASH_W     = 32;
    localparam int LG_W       = 4;
    localparam int LP_W       = 7;
    localparam int OP_W       = 2;
    localparam int ST_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [LG_W-1:0] LG_MIN   = 4'd1;
    localparam logic [LG_W-1:0] LG_MAX   = 4'd8;
    localparam logic [LG_W-1:0] LG_RESET = 4'd8;
    localparam logic [LP_W-1:0] LP_RESET = 7'd70;
    localparam logic [6:0]      PERCENT  = 7'd100;

    localparam logic [HASH_W-1:0] FNV_OFFSET = 32'h811C9DC5;
    localparam logic [HASH_W-1:0] FNV_PRIME  = 32'h01000193;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;
    localparam logic [ST_W-1:0] ST_CLEARED   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_PERCENT    = 2'd1;

    // one byte of fnv-1a
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction
endpackage

// ===== design/oaht_if.sv =====
// request, response and configuration channel interfaces
`timescale 1ns / 1ps
interface oaht_req_if;
    logic                          valid;
    logic                          ready;
    logic [oaht_pkg::OP_W-1:0]     operation;
    logic [oaht_pkg::KEY_W-1:0]    key;
    logic [oaht_pkg::VAL_W-1:0]    value;
    modport source (output valid, operation, key, value, input ready);
    modport sink   (input valid, operation, key, value, output ready);
endinterface

interface oaht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [oaht_pkg::ST_W-1:0]     status;
    logic [oaht_pkg::VAL_W-1:0]    found_value;
    logic [oaht_pkg::SLOT_W-1:0]   slot_index;
    modport source (output valid, status, found_value, slot_index, input ready);
    modport sink   (input valid, status, found_value, slot_index, output ready);
endinterface

interface oaht_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [oaht_pkg::CFG_IDX_W-1:0]    index;
    logic [oaht_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/open_addressed_hash_table_core.sv =====
// open-addressed key/value table with fnv-1a hashing and triangular probing
//
// req carries one item: add/update, lookup or clear, with a 32-bit key and
// value. rsp returns exactly one item per request: status, found value and
// slot. cfg writes table_size_log2 (index 0) and load_percent (index 1); it
// is always ready and must only be used while the table is idle.
// One request is handled at a time; req.ready is high only when idle.
// Steps of an add/lookup: the four key bytes are hashed through one shared
// fnv byte multiplier; each occupied slot probed takes a registered table
// read, then a compare; a free slot ends the walk; the result state closes
// the item. Clear, unknown codes and a refused add go straight to the
// result state.
// The result is held in the output register until rsp.ready; a stalled
// receiver simply holds the block in its result state.
// Reset clears occupied flags, the entry count and the configuration
// (size log2 8, load 70 percent); key, value and hash memories are not
// cleared and need no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module open_addressed_hash_table_core (
    input  logic          clk,
    input  logic          rst_n,
    oaht_req_if.sink      req,
    oaht_rsp_if.source    rsp,
    oaht_cfg_if.sink      cfg
);
    import oaht_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_HASH   = 5'b00010,
        S_PROBE  = 5'b00100,
        S_CMP    = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [VAL_W-1:0]      val_reg, val_next;
    logic [HASH_W-1:0]     hash_reg, hash_next;
    logic [1:0]            byte_reg, byte_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]      probe_cnt_reg, probe_cnt_next;
    logic [LG_W-1:0]       lg_reg, lg_next;
    logic [MAX_SLOTS-1:0]  occ_reg;
    logic [CNT_W-1:0]      entry_cnt_reg;
    logic [LG_W-1:0]       cfg_lg_reg;
    logic [LP_W-1:0]       cfg_lp_reg;
    logic [ST_W-1:0]       status_reg, status_next;
    logic [VAL_W-1:0]      fval_reg, fval_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;

    // table memories
    logic [KEY_W-1:0]      key_mem  [MAX_SLOTS];
    logic [VAL_W-1:0]      val_mem  [MAX_SLOTS];
    logic [HASH_W-1:0]     hash_mem [MAX_SLOTS];
    logic [KEY_W-1:0]      rd_key_reg;
    logic [VAL_W-1:0]      rd_val_reg;
    logic [HASH_W-1:0]     rd_hash_reg;

    logic                  ins_we, val_we, clr_all;
    logic [LG_W-1:0]       lg_eff;
    logic [CNT_W-1:0]      size;
    logic [SLOT_W-1:0]     mask;
    logic [16:0]           load_lhs, load_rhs;
    logic [HASH_W-1:0]     hash_step;
    logic [CNT_W-1:0]      cnt_inc;
    logic                  hit;

    assign req.ready = state_reg[0];
    assign rsp.valid = (state_reg == S_RESULT);
    assign rsp.status = status_reg;
    assign rsp.found_value = fval_reg;
    assign rsp.slot_index = slot_reg;
    assign cfg.ready = 1'b1;

    // size in use from the register, saturated into the supported range
    always_comb
    begin
        if (cfg_lg_reg < LG_MIN)
            lg_eff = LG_MIN;
        else if (cfg_lg_reg > LG_MAX)
            lg_eff = LG_MAX;
        else
            lg_eff = cfg_lg_reg;
    end

    assign size = CNT_W'(1) << lg_reg;
    assign mask = SLOT_W'(size - CNT_W'(1));

    // load check: (entries + 1) * 100 against load percent times size
    assign load_lhs = 17'({1'b0, entry_cnt_reg} + 10'd1) * 17'(PERCENT);
    assign load_rhs = 17'(cfg_lp_reg) << lg_eff;

    assign hash_step = fnv_step(hash_reg, key_reg[byte_reg*8 +: 8]);
    assign cnt_inc = probe_cnt_reg + CNT_W'(1);
    assign hit = (rd_hash_reg == hash_reg) && (rd_key_reg == key_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        key_next = key_reg;
        val_next = val_reg;
        hash_next = hash_reg;
        byte_next = byte_reg;
        idx_next = idx_reg;
        probe_cnt_next = probe_cnt_reg;
        lg_next = lg_reg;
        status_next = status_reg;
        fval_next = fval_reg;
        slot_next = slot_reg;
        ins_we = 1'b0;
        val_we = 1'b0;
        clr_all = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next = req.operation;
                    key_next = req.key;
                    val_next = req.value;
                    lg_next = lg_eff;
                    hash_next = FNV_OFFSET;
                    byte_next = 2'd0;
                    fval_next = '0;
                    slot_next = '0;
                    if (req.operation == OP_CLEAR)
                    begin
                        clr_all = 1'b1;
                        status_next = ST_CLEARED;
                        state_next = S_RESULT;
                    end
                    else if (req.operation == OP_ADD && load_lhs > load_rhs)
                    begin
                        status_next = ST_FULL;
                        state_next = S_RESULT;
                    end
                    else if (req.operation == OP_ADD || req.operation == OP_LOOKUP)
                    begin
                        state_next = S_HASH;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next = S_RESULT;
                    end
                end
            end
            S_HASH:
            begin
                hash_next = hash_step;
                byte_next = byte_reg + 2'd1;
                if (byte_reg == 2'd3)
                begin
                    idx_next = hash_step[SLOT_W-1:0] & mask;
                    probe_cnt_next = CNT_W'(1);
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (!occ_reg[idx_reg])
                begin
                    // free slot ends the walk
                    if (op_reg == OP_ADD)
                    begin
                        ins_we = 1'b1;
                        val_we = 1'b1;
                        status_next = ST_INSERTED;
                        slot_next = idx_reg;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (hit)
                begin
                    slot_next = idx_reg;
                    if (op_reg == OP_ADD)
                    begin
                        val_we = 1'b1;
                        status_next = ST_UPDATED;
                        fval_next = val_reg;
                    end
                    else
                    begin
                        status_next = ST_FOUND;
                        fval_next = rd_val_reg;
                    end
                    state_next = S_RESULT;
                end
                else if (cnt_inc >= size)
                begin
                    status_next = ST_FULL;
                    state_next = S_RESULT;
                end
                else
                begin
                    idx_next = (idx_reg + probe_cnt_reg[SLOT_W-1:0]) & mask;
                    probe_cnt_next = cnt_inc;
                    state_next = S_PROBE;
                end
            end
            S_RESULT:
            begin
                if (rsp.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg <= '0;
            entry_cnt_reg <= '0;
            cfg_lg_reg <= LG_RESET;
            cfg_lp_reg <= LP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_all)
            begin
                occ_reg <= '0;
                entry_cnt_reg <= '0;
            end
            else if (ins_we)
            begin
                occ_reg[idx_reg] <= 1'b1;
                entry_cnt_reg <= entry_cnt_reg + CNT_W'(1);
            end
            if (cfg.valid)
            begin
                if (cfg.index == CFG_TABLE_SIZE_LOG2)
                    cfg_lg_reg <= cfg.data[LG_W-1:0];
                else if (cfg.index == CFG_LOAD_PERCENT)
                    cfg_lp_reg <= cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        key_reg <= key_next;
        val_reg <= val_next;
        hash_reg <= hash_next;
        byte_reg <= byte_next;
        idx_reg <= idx_next;
        probe_cnt_reg <= probe_cnt_next;
        lg_reg <= lg_next;
        status_reg <= status_next;
        fval_reg <= fval_next;
        slot_reg <= slot_next;
    end

    // table memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ins_we)
        begin
            key_mem[idx_reg] <= key_reg;
            hash_mem[idx_reg] <= hash_reg;
        end
        if (val_we)
            val_mem[idx_reg] <= val_reg;
        if (state_reg == S_PROBE)
        begin
            rd_key_reg <= key_mem[idx_reg];
            rd_val_reg <= val_mem[idx_reg];
            rd_hash_reg <= hash_mem[idx_reg];
        end
    end

    // checks
    `OAHT_ASSERT_IMP(a_ready_no_result, req.ready, !rsp.valid)
    `OAHT_ASSERT_IMP(a_count_bound, 1'b1, entry_cnt_reg <= CNT_W'(MAX_SLOTS))
    `OAHT_ASSERT_IMP(a_probe_bound, state_reg == S_PROBE, probe_cnt_reg < size)
    `OAHT_ASSERT_NXT(a_clear_empties, clr_all, occ_reg == '0 && entry_cnt_reg == '0)
endmodule

// ===== test/oaht_scoreboard.sv =====
// scoreboard class: table predictor and expected-result store
`timescale 1ns / 1ps
package oaht_scoreboard_pkg;
    import oaht_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [VAL_W-1:0]  found_value;
        logic [SLOT_W-1:0] slot_index;
    } table_result_t;

    class oaht_scoreboard;
        logic [KEY_W-1:0]  keys   [MAX_SLOTS];
        logic [VAL_W-1:0]  vals   [MAX_SLOTS];
        logic [HASH_W-1:0] hashes [MAX_SLOTS];
        bit                used   [MAX_SLOTS];
        int unsigned       fill;
        logic [LG_W-1:0]   size_lg;
        logic [LP_W-1:0]   load_pct;
        table_result_t     pending[$];
        int                errors;

        function new();
            foreach (used[i]) used[i] = 0;
            fill = 0;
            size_lg = LG_RESET;
            load_pct = LP_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            if (idx == CFG_TABLE_SIZE_LOG2)
                size_lg = d[LG_W-1:0];
            else if (idx == CFG_LOAD_PERCENT)
                load_pct = d[LP_W-1:0];
        endfunction

        function int unsigned slot_count();
            int unsigned lg;
            lg = (size_lg == 0) ? 1 : size_lg;
            return (lg >= 8) ? MAX_SLOTS : (1 << lg);
        endfunction

        function logic [HASH_W-1:0] key_hash(logic [KEY_W-1:0] k);
            logic [HASH_W-1:0] h;
            h = 32'h811C9DC5;
            for (int b = 0; b < 4; b++)
            begin
                h = h ^ {24'd0, k[8*b +: 8]};
                h = h * 32'h01000193;
            end
            return h;
        endfunction

        // note an accepted request and queue its expected result
        function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                   logic [VAL_W-1:0] v);
            table_result_t r;
            int unsigned n, idx, cnt, where;
            logic [HASH_W-1:0] h;
            bit hit, ok;
            r = '{ST_NOT_FOUND, '0, '0};
            if (op == OP_CLEAR)
            begin
                foreach (used[i]) used[i] = 0;
                fill = 0;
                r.status = ST_CLEARED;
            end
            else if (op == OP_ADD || op == OP_LOOKUP)
            begin
                n = slot_count();
                h = key_hash(k);
                if (op == OP_ADD && (fill + 1) * 100 > n * load_pct)
                    r.status = ST_FULL;
                else
                begin
                    // triangular probe walk
                    idx = h & (n - 1);
                    cnt = 1;
                    hit = 0;
                    ok = 1;
                    while (used[idx] && ok && !hit)
                    begin
                        if (hashes[idx] == h && keys[idx] == k)
                            hit = 1;
                        else
                        begin
                            idx = (idx + cnt) & (n - 1);
                            cnt++;
                            if (cnt >= n) ok = 0;
                        end
                    end
                    where = idx;
                    if (!ok)
                        r.status = ST_FULL;
                    else if (op == OP_LOOKUP)
                    begin
                        if (hit)
                            r = '{ST_FOUND, vals[where], where[7:0]};
                    end
                    else if (hit)
                    begin
                        vals[where] = v;
                        r = '{ST_UPDATED, v, where[7:0]};
                    end
                    else
                    begin
                        keys[where] = k;
                        vals[where] = v;
                        hashes[where] = h;
                        used[where] = 1;
                        fill++;
                        r = '{ST_INSERTED, '0, where[7:0]};
                    end
                end
            end
            pending.push_back(r);
        endfunction

        // compare one response with the oldest expectation
        function void check_response(table_result_t got);
            table_result_t exp_r;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected response st=%0d val=%h slot=%0d",
                             got.status, got.found_value, got.slot_index);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp st=%0d val=%h slot=%0d, got st=%0d val=%h slot=%0d",
                             exp_r.status, exp_r.found_value, exp_r.slot_index,
                             got.status, got.found_value, got.slot_index);
            end
        endfunction
    endclass
endpackage

// ===== test/open_addressed_hash_table_core_tb.sv =====
// testbench top of the open-addressed hash table core
`timescale 1ns / 1ps
module open_addressed_hash_table_core_tb;
    import oaht_pkg::*;
    import oaht_scoreboard_pkg::*;

    // operation code with no meaning, answered as not found
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    logic clk;
    logic rst_n;
    oaht_req_if req ();
    oaht_rsp_if rsp ();
    oaht_cfg_if cfg ();

    open_addressed_hash_table_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    oaht_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    int  quiet_cycles;
    bit  timed_out;
    logic [KEY_W-1:0] key_pool[16];

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // response side: random stalls, long hold-off on request
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // checking and watchdog on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                sb.check_response('{rsp.status, rsp.found_value, rsp.slot_index});
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000 && !timed_out)
            begin
                timed_out = 1'b1;
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // send one request and wait for its acceptance; the block is busy in the
    // cycle after an accept, so valid is dropped or replaced at the negedge after the accept
    task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                             logic [VAL_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.operation <= op;
        req.key <= k;
        req.value <= v;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(op, k, v);
        @(negedge clk);
    endtask

    // wait until every expected response has arrived
    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        drain();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= d;
        do
            @(posedge clk);
        while (!cfg.ready);
        sb.write_reg(idx, d);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // random item: mostly adds and lookups over a small key pool
    task automatic random_item();
        int r;
        logic [OP_W-1:0] op;
        logic [KEY_W-1:0] k;
        r = $urandom_range(99);
        if (r < 45) op = OP_ADD;
        else if (r < 90) op = OP_LOOKUP;
        else if (r < 97) op = OP_CLEAR;
        else op = OP_RESERVED;
        k = ($urandom_range(3) == 0) ? $urandom() : key_pool[$urandom_range(15)];
        send_item(op, k, $urandom());
    endtask

    initial
    begin
        sb = new();
        timed_out = 1'b0;
        quiet_cycles = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_ADD;
        req.key = '0;
        req.value = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_TABLE_SIZE_LOG2;
        cfg.data = '0;
        foreach (key_pool[i]) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        send_item(OP_LOOKUP, 32'h0, 32'h0);
        send_item(OP_ADD, 32'h0, 32'hFFFF_FFFF);
        send_item(OP_ADD, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_ADD, 32'h0, 32'h1234_5678);
        send_item(OP_LOOKUP, 32'h0, 32'h0);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_CLEAR, 32'h0, 32'h0);
        send_item(OP_LOOKUP, 32'h0, 32'h0);
        // two slot table, size log2 zero treated as one
        write_reg(CFG_TABLE_SIZE_LOG2, 7'd0);
        write_reg(CFG_LOAD_PERCENT, 7'd100);
        for (int i = 0; i < 4; i++) send_item(OP_ADD, key_pool[i], $urandom());
        send_item(OP_LOOKUP, key_pool[0], 0);
        // size beyond maximum and load above hundred
        write_reg(CFG_TABLE_SIZE_LOG2, 7'd15);
        write_reg(CFG_LOAD_PERCENT, 7'd127);
        for (int i = 0; i < 4; i++) send_item(OP_ADD, key_pool[i], $urandom());
        // load zero refuses every add, even an update
        write_reg(CFG_LOAD_PERCENT, 7'd0);
        send_item(OP_ADD, key_pool[0], 32'h5);
        send_item(OP_LOOKUP, key_pool[1], 0);
        // shrink while entries are held
        write_reg(CFG_LOAD_PERCENT, 7'd100);
        write_reg(CFG_TABLE_SIZE_LOG2, 7'd2);
        send_item(OP_LOOKUP, key_pool[2], 0);
        send_item(OP_ADD, key_pool[5], $urandom());

        // random phases over several settings and idling mixes
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            write_reg(CFG_TABLE_SIZE_LOG2, (ph == 0) ? 7'd8 : (ph == 1) ? 7'd1 :
                      7'($urandom_range(15)));
            write_reg(CFG_LOAD_PERCENT, (ph == 2) ? 7'd1 : (ph == 3) ? 7'd100 :
                      7'($urandom_range(127)));
            if (ph == 5)
                hold_cycles = 300;
            for (int i = 0; i < 75; i++)
                random_item();
            // pause until all results are back
            if (ph == 7)
                drain();
        end
        for (int i = 0; i < 15; i++)
            key_pool[i] = key_pool[i] ^ 32'hA5A5_5A5A;
        for (int i = 0; i < 20; i++)
            random_item();

        // end of run
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
